// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Entry, command and result layouts, status and action codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY        = 16;
  localparam int PRIORITY_LEVELS = 5;
  localparam int IDX_W           = $clog2(CAPACITY);
  localparam int CNT_W           = $clog2(CAPACITY + 1);
  localparam int PRIO_W          = 3;
  localparam int VAL_W           = 8;

  localparam logic       ACT_ENQUEUE = 1'b0;
  localparam logic       ACT_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic              action;
    logic [VAL_W-1:0]  data_value;
    logic [PRIO_W-1:0] priority_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VAL_W-1:0]  out_value;
    logic [PRIO_W-1:0] out_priority;
  } result_t;

  typedef struct packed {
    logic             enq;
    logic             deq;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  function automatic logic [PRIO_W-1:0] sat_priority(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] r;
    r = p;
    if (p == '0) r = PRIO_W'(1);
    else if (p > PRIO_W'(PRIORITY_LEVELS)) r = PRIO_W'(PRIORITY_LEVELS);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; keeps it, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire  logic             clk,
  input  wire  logic [IDX_W-1:0] index,
  input  wire  cell_ctl_t        ctl,
  input  wire  entry_t           left_entry,
  input  wire  logic             left_ge,
  input  wire  entry_t           right_entry,
  output entry_t                 entry,
  output logic                   ge
);

  logic occupied;

  assign occupied = {1'b0, index} < ctl.count;
  // entry stays ahead of an incoming item of this priority
  assign ge = occupied && (entry.prio >= ctl.new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctl.deq) begin
      entry <= right_entry;
    end else if (ctl.enq && !ge) begin
      entry <= left_ge ? ctl.new_entry : left_entry;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, FIFO within a priority
// Row of compare-and-shift cells kept in service order, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the command transfers at a clock edge where
//   start is high and busy is low. Enqueue (action 0) stores data_value with
//   its priority saturated to 1..5 behind every entry of equal or higher
//   priority. Dequeue (action 1) removes the head entry.
//   Each command yields one result on the result port, marked by strobe for
//   one cycle, in the cycle after its transfer. Status reports enqueued,
//   dequeued, empty (dequeue on empty queue) or full (enqueue dropped);
//   value and priority are zero except on a dequeue that finds an entry.
//   Throughput is one command per cycle while busy is low: all cells compare
//   against the incoming priority and shift in parallel, so the whole cell
//   row is updated at once.
//   Reset empties the queue; busy stays high until the first edge without reset.
//   The receiver cannot stall: every strobe cycle is a transfer.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  input  wire  cmd_t cmd,
  output logic       strobe,
  output result_t    result
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_deq;
  logic             empty;
  logic             full;
  cell_ctl_t        ctl;
  result_t          result_next;
  entry_t           cell_entry [CAPACITY];
  logic             cell_ge    [CAPACITY];

  assign accept = start && !busy;
  assign is_deq = (cmd.action == ACT_DEQUEUE);
  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(CAPACITY));

  always_comb begin
    ctl.enq             = accept && !is_deq && !full;
    ctl.deq             = accept && is_deq && !empty;
    ctl.new_entry.prio  = sat_priority(cmd.priority_level);
    ctl.new_entry.value = cmd.data_value;
    ctl.count           = count;

    count_next = count;
    if (ctl.enq) count_next = count + CNT_W'(1);
    else if (ctl.deq) count_next = count - CNT_W'(1);

    result_next = '0;
    if (is_deq) begin
      if (empty) begin
        result_next.status = ST_EMPTY;
      end else begin
        result_next.status       = ST_DEQUEUED;
        result_next.out_value    = cell_entry[0].value;
        result_next.out_priority = cell_entry[0].prio;
      end
    end else begin
      result_next.status = full ? ST_FULL : ST_ENQUEUED;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    logic   left_ge;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry = ctl.new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .index       (IDX_W'(i)),
      .ctl         (ctl),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ge          (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      busy   <= 1'b1;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      busy   <= 1'b0;
      strobe <= accept;
    end
    result <= result_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe)
    else $error("result missing after command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !strobe)
    else $error("result without command transfer");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    ctl.enq |=> count == $past(count) + CNT_W'(1))
    else $error("enqueue did not grow the queue");

  a_deq_prio: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == ST_DEQUEUED) |->
      (result.out_priority != '0 && result.out_priority <= PRIO_W'(PRIORITY_LEVELS)))
    else $error("dequeued priority out of range");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: self-checking bench for the stable priority queue
// Sends enqueue and dequeue commands with random gaps, then back to back, and
// keeps a behavioral shadow queue that predicts each result. Every strobed
// result is checked field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int          PHASE_LEN    = 570;
  localparam int          RANDOM_CMDS  = 1690;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          SETTLE_TICKS = 8;

  typedef struct {
    cmd_t        c;
    int unsigned idle_pct;
    bit          drain;
  } pending_cmd_t;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  pending_cmd_t pending_cmds[$];
  result_t      expected_results[$];
  entry_t       shadow_queue[$];
  int unsigned  n_queued    = 0;
  int unsigned  n_errors    = 0;
  int unsigned  cycle_count = 0;

  stable_priority_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t queue_response(cmd_t c);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (c.action == ACT_DEQUEUE) begin
      if (shadow_queue.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = shadow_queue.pop_front();
        r.status       = ST_DEQUEUED;
        r.out_value    = e.value;
        r.out_priority = e.prio;
      end
    end else if (shadow_queue.size() >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      e.value = c.data_value;
      e.prio  = c.priority_level;
      if (e.prio < PRIO_W'(1)) e.prio = PRIO_W'(1);
      else if (e.prio > PRIO_W'(PRIORITY_LEVELS)) e.prio = PRIO_W'(PRIORITY_LEVELS);
      // new entry goes behind all entries of equal or higher priority
      pos = 0;
      while (pos < shadow_queue.size() && shadow_queue[pos].prio >= e.prio) pos++;
      shadow_queue.insert(pos, e);
      r.status = ST_ENQUEUED;
    end
    return r;
  endfunction

  task automatic queue_cmd(logic act, logic [VAL_W-1:0] v, logic [PRIO_W-1:0] p);
    pending_cmd_t pc;
    pc.c.action         = act;
    pc.c.data_value     = v;
    pc.c.priority_level = p;
    if (n_queued < PHASE_LEN) pc.idle_pct = 18;
    else if (n_queued < 2 * PHASE_LEN) pc.idle_pct = 88;
    else pc.idle_pct = 0;
    pc.drain = (n_queued == PHASE_LEN) || (n_queued == 2 * PHASE_LEN);
    pending_cmds.push_back(pc);
    n_queued++;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    n_errors++;
  endtask

  // driver: one command transfer per start && !busy edge
  always @(posedge clk) begin : driver
    logic took;
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      took = start && !busy;
      if (took || !start) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain && (took || expected_results.size() != 0)) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < pending_cmds[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          cmd   <= pending_cmds[0].c;
          void'(pending_cmds.pop_front());
        end
      end
    end
  end

  // monitor: predict on command transfer, check on result transfer
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (start && !busy) expected_results.push_back(queue_response(cmd));
      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending, status", 32'(result.status), 0);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.out_value !== want.out_value)
            report_mismatch("out_value", 32'(result.out_value), 32'(want.out_value));
          if (result.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(result.out_priority),
                            32'(want.out_priority));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_stable_priority_queue NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned       seg_len;
    int unsigned       enq_pct;
    int unsigned       n_rand;
    logic [PRIO_W-1:0] p;

    // empty dequeue, saturation at both ends, extreme values, FIFO ties
    queue_cmd(ACT_DEQUEUE, 8'hFF, 3'd7);
    queue_cmd(ACT_ENQUEUE, 8'h00, 3'd0);
    queue_cmd(ACT_ENQUEUE, 8'hFF, 3'd7);
    queue_cmd(ACT_ENQUEUE, 8'h80, 3'd6);
    queue_cmd(ACT_ENQUEUE, 8'h7F, 3'd5);
    queue_cmd(ACT_ENQUEUE, 8'h01, 3'd3);
    queue_cmd(ACT_ENQUEUE, 8'h02, 3'd3);
    queue_cmd(ACT_ENQUEUE, 8'h03, 3'd1);
    queue_cmd(ACT_ENQUEUE, 8'h04, 3'd3);
    queue_cmd(ACT_ENQUEUE, 8'h05, 3'd2);
    repeat (10) queue_cmd(ACT_DEQUEUE, 8'h00, 3'd0);

    // segments biased toward filling, draining or mixed traffic
    n_rand = 0;
    while (n_rand < RANDOM_CMDS) begin
      seg_len = $urandom_range(40, 8);
      case ($urandom_range(3))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(9) < 8) p = PRIO_W'($urandom_range(PRIORITY_LEVELS, 1));
        else p = PRIO_W'($urandom_range(7));
        queue_cmd(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE,
                  VAL_W'($urandom), p);
        n_rand++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results outstanding at end", 0, expected_results.size());

    if (n_errors == 0) begin
      $display("tb_stable_priority_queue OK");
    end else begin
      $display("tb_stable_priority_queue NOT OK");
    end
    $finish;
  end

endmodule
